@@ rtl/rlc_pkg.sv @@
// ----------------------------------------------------------------------------
// rlc_pkg: shared types, codes and per-character functions
// Holds the line state record, the queue beat and result formats, the fixed
// keyword tables and the functions that advance and classify a line.
// ----------------------------------------------------------------------------
package rlc_pkg;

  // Character codes
  localparam logic [7:0] CH_LF   = 8'h0A;
  localparam logic [7:0] CH_CR   = 8'h0D;
  localparam logic [7:0] CH_SP   = 8'h20;
  localparam logic [7:0] CH_TAB  = 8'h09;
  localparam logic [7:0] CH_VT   = 8'h0B;
  localparam logic [7:0] CH_FF   = 8'h0C;
  localparam logic [7:0] CH_ZERO = 8'h30;
  localparam logic [7:0] CH_NINE = 8'h39;

  // Line phases
  localparam logic [1:0] PH_SEQ   = 2'd0;
  localparam logic [1:0] PH_GAP   = 2'd1;
  localparam logic [1:0] PH_BODY  = 2'd2;
  localparam logic [1:0] PH_EVENT = 2'd3;

  // Prefix flag bits; the event-miss flag shares bit 0 while in the first token
  localparam int F_EVMISS = 0;
  localparam int F_OK     = 0;
  localparam int F_OKSP   = 1;
  localparam int F_ERR    = 2;
  localparam int F_ERRSP  = 3;

  // Line kinds
  localparam logic [1:0] KIND_EVENT = 2'd0;
  localparam logic [1:0] KIND_UNSOL = 2'd1;
  localparam logic [1:0] KIND_RESP  = 2'd2;
  localparam logic [1:0] KIND_MALF  = 2'd3;

  // Malformed reasons
  localparam logic [1:0] MR_NONE    = 2'd0;
  localparam logic [1:0] MR_BAD_SEQ = 2'd1;
  localparam logic [1:0] MR_BAD_ERR = 2'd2;
  localparam logic [1:0] MR_NO_VERB = 2'd3;

  localparam logic [3:0] POS_MAX = 4'd15;

  // Keyword tables, first character in the top byte
  localparam logic [39:0] EVENT_WORD = "event";
  localparam logic [87:0] ERR_WORD [8] = '{
    {"bad_arg", 32'h0}, {"bad_cmd", 32'h0}, {"busy", 56'h0},
    {"not_", "ready", 16'h0}, {"timeout", 32'h0}, {"safety", 40'h0},
    {"io", 72'h0}, "unsupported"
  };
  localparam logic [3:0] ERR_LEN [8] = '{
    4'd7, 4'd7, 4'd4, 4'd9, 4'd7, 4'd6, 4'd2, 4'd11
  };

  // One beat between front and back: a character, the end of a line, or both
  typedef struct packed {
    logic       eol;
    logic       has_char;
    logic [7:0] ch;
  } q_entry_t;

  typedef struct packed {
    logic [1:0]  phase;
    logic [3:0]  pos;
    logic [13:0] seq_val;
    logic        seq_ok;
    logic [7:0]  err_mask;
    logic [3:0]  flags;
    logic        payload_seen;
  } line_state_t;

  typedef struct packed {
    logic [1:0]  kind;
    logic        has_seq;
    logic [13:0] seq_num;
    logic        resp_kind;
    logic [2:0]  err_code;
    logic        has_payload;
    logic [1:0]  mal_reason;
  } line_class_t;

  localparam line_state_t LINE_RESET = '{
    phase: PH_SEQ, pos: 4'd0, seq_val: 14'd0, seq_ok: 1'b1,
    err_mask: 8'hFF, flags: 4'd0, payload_seen: 1'b0
  };

  function automatic logic [3:0] pos_inc(input logic [3:0] p);
    return (p == POS_MAX) ? p : p + 4'd1;
  endfunction

  // Advance the state by one character of the text after the gap
  function automatic line_state_t body_char(input line_state_t s, input logic [7:0] c);
    line_state_t n;
    logic [3:0]  idx;
    logic [3:0]  idx_c;
    logic [7:0]  wc;
    n     = s;
    idx   = s.pos - 4'd4;
    idx_c = (idx > 4'd10) ? 4'd10 : idx;
    case (s.pos)
      4'd0: begin
        n.flags = {1'b0, (c == "e"), 1'b0, (c == "o")};
      end
      4'd1: begin
        if (c != "k") n.flags[F_OK] = 1'b0;
        if (c != "r") n.flags[F_ERR] = 1'b0;
      end
      4'd2: begin
        if (n.flags[F_OK] && c == CH_SP) n.flags[F_OKSP] = 1'b1;
        if (c != "r") n.flags[F_ERR] = 1'b0;
      end
      4'd3: begin
        if (n.flags[F_ERR] && c == CH_SP) n.flags[F_ERRSP] = 1'b1;
      end
      default: begin
      end
    endcase
    if (s.pos >= 4'd3 && n.flags[F_OKSP]) n.payload_seen = 1'b1;
    // Knock out error words that no longer match
    if (s.pos >= 4'd4 && n.flags[F_ERRSP]) begin
      for (int w = 0; w < 8; w++) begin
        wc = ERR_WORD[w][8 * (10 - int'(idx_c)) +: 8];
        if (idx >= ERR_LEN[w] || wc != c) n.err_mask[w] = 1'b0;
      end
    end
    n.pos = pos_inc(s.pos);
    return n;
  endfunction

  // Advance the line state by one character
  function automatic line_state_t take_char(input line_state_t s, input logic [7:0] c);
    line_state_t n;
    logic [3:0]  p_c;
    n   = s;
    p_c = (s.pos > 4'd4) ? 4'd4 : s.pos;
    case (s.phase)
      PH_SEQ: begin
        if (c == CH_SP || c == CH_TAB) begin
          if (!s.flags[F_EVMISS] && s.pos == 4'd5 && c == CH_SP) begin
            n.phase = PH_EVENT;
          end else begin
            if (s.pos != 4'd4) n.seq_ok = 1'b0;
            n.phase = PH_GAP;
          end
          n.pos   = 4'd0;
          n.flags = 4'd0;
        end else begin
          if (s.pos >= 4'd5 || EVENT_WORD[8 * (4 - int'(p_c)) +: 8] != c)
            n.flags[F_EVMISS] = 1'b1;
          if (s.pos < 4'd4 && c >= CH_ZERO && c <= CH_NINE)
            n.seq_val = (s.seq_val << 3) + (s.seq_val << 1) + {6'd0, c - CH_ZERO};
          else
            n.seq_ok = 1'b0;
          n.pos = pos_inc(s.pos);
        end
      end
      PH_GAP: begin
        if (!(c == CH_SP || c == CH_TAB || c == CH_VT || c == CH_FF || c == CH_CR)) begin
          n.phase = PH_BODY;
          n.pos   = 4'd0;
          n       = body_char(n, c);
        end
      end
      PH_BODY: begin
        n = body_char(s, c);
      end
      default: begin
      end
    endcase
    return n;
  endfunction

  // Classify a finished line
  function automatic line_class_t classify(input line_state_t s);
    line_class_t r;
    logic [3:0]  f;
    logic [3:0]  n;
    logic        found;
    logic [2:0]  found_w;
    r       = '{kind: KIND_UNSOL, has_seq: 1'b0, seq_num: 14'd0, resp_kind: 1'b0,
                err_code: 3'd0, has_payload: 1'b0, mal_reason: MR_NONE};
    f       = s.flags;
    n       = s.pos;
    found   = 1'b0;
    found_w = 3'd0;
    for (int w = 0; w < 8; w++) begin
      if (s.err_mask[w] && n >= 4'd4 && ERR_LEN[w] == n - 4'd4) begin
        found   = 1'b1;
        found_w = 3'(w);
      end
    end
    if (s.phase == PH_SEQ) begin
      r.kind = (!f[F_EVMISS] && n == 4'd5) ? KIND_EVENT : KIND_UNSOL;
    end else if (s.phase == PH_EVENT) begin
      r.kind = KIND_EVENT;
    end else if (!s.seq_ok) begin
      if ((f[F_OK] && n >= 4'd2) || (f[F_ERR] && n >= 4'd3)) begin
        r.kind       = KIND_MALF;
        r.mal_reason = MR_BAD_SEQ;
      end
    end else begin
      r.has_seq = 1'b1;
      r.seq_num = s.seq_val;
      if (f[F_OK] && n == 4'd2) begin
        r.kind = KIND_RESP;
      end else if (f[F_OKSP]) begin
        r.kind        = KIND_RESP;
        r.has_payload = s.payload_seen;
      end else if (f[F_ERRSP]) begin
        if (found) begin
          r.kind      = KIND_RESP;
          r.resp_kind = 1'b1;
          r.err_code  = found_w;
        end else begin
          r.kind       = KIND_MALF;
          r.mal_reason = MR_BAD_ERR;
        end
      end else begin
        r.kind       = KIND_MALF;
        r.mal_reason = MR_NO_VERB;
      end
    end
    return r;
  endfunction

endpackage

@@ rtl/rlc_front.sv @@
// ----------------------------------------------------------------------------
// rlc_front: byte intake
// Holds each byte back by one beat so that a carriage return directly before
// a newline can be dropped, and folds the end of line into the last beat.
// ----------------------------------------------------------------------------
module rlc_front
  import rlc_pkg::*;
(
  input  logic       clk,
  input  logic       rst,
  input  logic       byte_valid,
  output logic       byte_stall,
  input  logic [7:0] line_byte,
  input  logic       q_full,
  output logic       q_push,
  output q_entry_t   q_data
);

  logic       pending;
  logic [7:0] pending_byte;
  logic       accept;
  logic       is_lf;

  assign byte_stall = q_full;
  assign accept     = byte_valid && !q_full;
  assign is_lf      = (line_byte == CH_LF);

  // Push the held byte, or the bare end of line, when an accepted byte follows a held one or is a newline
  assign q_push = accept && (is_lf || pending);

  always_comb begin
    q_data.eol      = is_lf;
    q_data.has_char = pending && !(is_lf && pending_byte == CH_CR);
    q_data.ch       = pending_byte;
  end

  // Hold the newest byte until the next one shows what follows it
  always_ff @(posedge clk) begin
    if (rst) begin
      pending <= 1'b0;
    end else if (accept) begin
      pending <= !is_lf;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      pending_byte <= line_byte;
    end
  end

endmodule

@@ rtl/rlc_queue.sv @@
// ----------------------------------------------------------------------------
// rlc_queue: two-beat queue between intake and classifier
// Lets the intake keep taking bytes while the classifier waits on its output.
// ----------------------------------------------------------------------------
module rlc_queue
  import rlc_pkg::*;
(
  input  logic     clk,
  input  logic     rst,
  input  logic     push,
  input  q_entry_t push_data,
  output logic     full,
  input  logic     pop,
  output logic     valid,
  output q_entry_t data
);

  q_entry_t   slot [2];
  logic       wr_ptr;
  logic       rd_ptr;
  logic [1:0] count;

  assign full  = (count == 2'd2);
  assign valid = (count != 2'd0);
  assign data  = slot[rd_ptr];

  // Advance pointers and occupancy
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= 1'b0;
      rd_ptr <= 1'b0;
      count  <= 2'd0;
    end else begin
      if (push) wr_ptr <= !wr_ptr;
      if (pop) rd_ptr <= !rd_ptr;
      case ({push, pop})
        2'b10:   count <= count + 2'd1;
        2'b01:   count <= count - 2'd1;
        default: count <= count;
      endcase
    end
  end

  // Store the incoming beat
  always_ff @(posedge clk) begin
    if (push) begin
      slot[wr_ptr] <= push_data;
    end
  end

endmodule

@@ rtl/rlc_back.sv @@
// ----------------------------------------------------------------------------
// rlc_back: line classifier
// Runs the per-line state one character a beat and, at end of line, loads
// the classification into the output register.
// ----------------------------------------------------------------------------
module rlc_back
  import rlc_pkg::*;
(
  input  logic        clk,
  input  logic        rst,
  input  logic        q_valid,
  input  q_entry_t    q_data,
  output logic        q_pop,
  output logic        class_valid,
  input  logic        class_stall,
  output line_class_t class_data
);

  line_state_t state;
  line_state_t after_char;
  line_state_t state_next;
  line_class_t result;

  // Take a beat unless it ends a line and the output register is still held
  assign q_pop = q_valid && (!q_data.eol || !class_valid || !class_stall);

  always_comb begin
    after_char = q_data.has_char ? take_char(state, q_data.ch) : state;
    result     = classify(after_char);
    state_next = q_data.eol ? LINE_RESET : after_char;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= LINE_RESET;
    end else if (q_pop) begin
      state <= state_next;
    end
  end

  // Output register: load at end of line, drop once taken
  always_ff @(posedge clk) begin
    if (rst) begin
      class_valid <= 1'b0;
    end else if (q_pop && q_data.eol) begin
      class_valid <= 1'b1;
    end else if (!class_stall) begin
      class_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (q_pop && q_data.eol) begin
      class_data <= result;
    end
  end

endmodule

@@ rtl/response_line_classifier_top.sv @@
// ----------------------------------------------------------------------------
// response_line_classifier_top: reply line classifier
// Channel   | Signals                         | Beat
// ----------+---------------------------------+------------------------------
// byte in   | byte_valid, byte_stall          | line_byte
// class out | class_valid, class_stall        | line_kind .. malformed_reason
//
// One byte is taken every cycle while the two-beat queue has room.
// After its newline is taken, a classification passes through the queue and
// is loaded into the output register, which holds it while class_stall is high;
// the queue keeps taking bytes until it fills.
// Reset (rst, synchronous) empties the queue, clears the held byte and
// returns the line state to the start of a line.
// ----------------------------------------------------------------------------
module response_line_classifier_top
  import rlc_pkg::*;
(
  input  logic        clk,
  input  logic        rst,
  input  logic        byte_valid,
  output logic        byte_stall,
  input  logic [7:0]  line_byte,
  output logic        class_valid,
  input  logic        class_stall,
  output logic [1:0]  line_kind,
  output logic        has_sequence,
  output logic [13:0] sequence_number,
  output logic        response_kind,
  output logic [2:0]  error_code,
  output logic        has_payload,
  output logic [1:0]  malformed_reason
);

  logic        q_push;
  logic        q_full;
  logic        q_pop;
  logic        q_valid;
  q_entry_t    q_in;
  q_entry_t    q_out;
  line_class_t class_data;

  rlc_front u_front (
    .clk        (clk),
    .rst        (rst),
    .byte_valid (byte_valid),
    .byte_stall (byte_stall),
    .line_byte  (line_byte),
    .q_full     (q_full),
    .q_push     (q_push),
    .q_data     (q_in)
  );

  rlc_queue u_queue (
    .clk       (clk),
    .rst       (rst),
    .push      (q_push),
    .push_data (q_in),
    .full      (q_full),
    .pop       (q_pop),
    .valid     (q_valid),
    .data      (q_out)
  );

  rlc_back u_back (
    .clk         (clk),
    .rst         (rst),
    .q_valid     (q_valid),
    .q_data      (q_out),
    .q_pop       (q_pop),
    .class_valid (class_valid),
    .class_stall (class_stall),
    .class_data  (class_data)
  );

  assign line_kind        = class_data.kind;
  assign has_sequence     = class_data.has_seq;
  assign sequence_number  = class_data.seq_num;
  assign response_kind    = class_data.resp_kind;
  assign error_code       = class_data.err_code;
  assign has_payload      = class_data.has_payload;
  assign malformed_reason = class_data.mal_reason;

endmodule

@@ rtl/rlc_checker.sv @@
// ----------------------------------------------------------------------------
// rlc_checker: port-level checks for the reply line classifier
// Watches the output beats for stall holding and for consistency between kind and detail fields.
// ----------------------------------------------------------------------------
module rlc_checker
  import rlc_pkg::*;
(
  input logic        clk,
  input logic        rst,
  input logic        class_valid,
  input logic        class_stall,
  input logic [1:0]  line_kind,
  input logic        has_sequence,
  input logic [13:0] sequence_number,
  input logic        response_kind,
  input logic        has_payload,
  input logic [1:0]  malformed_reason
);

  // Hold a stalled beat
  a_stall_hold: assert property (@(posedge clk) disable iff (rst)
    class_valid && class_stall |=> class_valid && $stable(line_kind)
      && $stable(sequence_number))
    else $error("stalled classification changed");

  // Give a reason exactly for malformed lines
  a_reason_kind: assert property (@(posedge clk) disable iff (rst)
    class_valid |-> ((line_kind == KIND_MALF) == (malformed_reason != MR_NONE)))
    else $error("malformed reason does not match line kind");

  // Carry a sequence number on every response
  a_resp_seq: assert property (@(posedge clk) disable iff (rst)
    class_valid && line_kind == KIND_RESP |-> has_sequence)
    else $error("response without sequence number");

  // Keep error and payload marks to responses, never both
  a_resp_detail: assert property (@(posedge clk) disable iff (rst)
    class_valid && (response_kind || has_payload)
      |-> line_kind == KIND_RESP && !(response_kind && has_payload))
    else $error("response detail on wrong line kind");

  // Bound the four-digit sequence value
  a_seq_range: assert property (@(posedge clk) disable iff (rst)
    class_valid && has_sequence |-> sequence_number <= 14'd9999)
    else $error("sequence number out of range");

endmodule

bind response_line_classifier_top rlc_checker u_rlc_checker (
  .clk              (clk),
  .rst              (rst),
  .class_valid      (class_valid),
  .class_stall      (class_stall),
  .line_kind        (line_kind),
  .has_sequence     (has_sequence),
  .sequence_number  (sequence_number),
  .response_kind    (response_kind),
  .has_payload      (has_payload),
  .malformed_reason (malformed_reason)
);

@@ bench/response_line_classifier_top_tb.sv @@
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// response_line_classifier_top_tb: self-checking bench for the reply classifier
// Feeds the classifier a byte stream of directed and random reply lines. A
// line model predicts one classification per newline, and every classification
// taken from the block is checked field by field against the oldest one due.
// Both channels idle and stall at random. One long receiver hold-off fills the
// block so that it stalls its input.
// ----------------------------------------------------------------------------

typedef struct packed {
  logic [1:0]  line_kind;
  logic        has_sequence;
  logic [13:0] sequence_number;
  logic        response_kind;
  logic [2:0]  error_code;
  logic        has_payload;
  logic [1:0]  malformed_reason;
} line_verdict_t;

typedef enum logic [1:0] {IN_TOKEN, IN_GAP, IN_BODY, IN_EVENT} scan_phase_t;

// Line model: tracks the reply line being received and keeps the verdicts due
class line_class_book;
  scan_phase_t   phase;
  int unsigned   col;
  logic [13:0]   seq_acc;
  bit            seq_good;
  bit            event_miss;
  bit            saw_ok;
  bit            saw_ok_sp;
  bit            saw_err;
  bit            saw_err_sp;
  bit            saw_payload;
  bit            cr_held;
  logic [7:0]    word_alive;
  string         err_word [8];
  string         event_text;
  line_verdict_t pending [$];
  int unsigned   failures;
  int unsigned   lines_checked;
  int unsigned   kind_seen [4];

  function new();
    err_word   = '{"bad_arg", "bad_cmd", "busy", {"not_", "ready"},
                   "timeout", "safety", "io", "unsupported"};
    event_text = "event";
    cr_held    = 1'b0;
    failures   = 0;
    lines_checked = 0;
    kind_seen  = '{0, 0, 0, 0};
    start_line();
  endfunction

  function void start_line();
    phase       = IN_TOKEN;
    col         = 0;
    seq_acc     = '0;
    seq_good    = 1'b1;
    word_alive  = 8'hFF;
    event_miss  = 1'b0;
    saw_ok      = 1'b0;
    saw_ok_sp   = 1'b0;
    saw_err     = 1'b0;
    saw_err_sp  = 1'b0;
    saw_payload = 1'b0;
  endfunction

  function void bump();
    if (col < 15) col++;
  endfunction

  // Match the text after the gap against ok / err and the error words
  function void body_step(logic [7:0] c);
    if (col == 0) begin
      saw_ok     = (c == "o");
      saw_err    = (c == "e");
      saw_ok_sp  = 1'b0;
      saw_err_sp = 1'b0;
    end else if (col == 1) begin
      if (c != "k") saw_ok = 1'b0;
      if (c != "r") saw_err = 1'b0;
    end else if (col == 2) begin
      if (saw_ok && c == rlc_pkg::CH_SP) saw_ok_sp = 1'b1;
      if (c != "r") saw_err = 1'b0;
    end else if (col == 3) begin
      if (saw_err && c == rlc_pkg::CH_SP) saw_err_sp = 1'b1;
    end
    if (col >= 3 && saw_ok_sp) saw_payload = 1'b1;
    if (col >= 4 && saw_err_sp) begin
      for (int w = 0; w < 8; w++) begin
        if (col - 4 >= err_word[w].len() || err_word[w][col - 4] != c)
          word_alive[w] = 1'b0;
      end
    end
    bump();
  endfunction

  // Advance the line by one character that is not a line end
  function void scan_char(logic [7:0] c);
    case (phase)
      IN_TOKEN: begin
        if (c == rlc_pkg::CH_SP || c == rlc_pkg::CH_TAB) begin
          if (!event_miss && col == 5 && c == rlc_pkg::CH_SP) begin
            phase = IN_EVENT;
          end else begin
            if (col != 4) seq_good = 1'b0;
            phase = IN_GAP;
          end
          col        = 0;
          event_miss = 1'b0;
          saw_ok     = 1'b0;
          saw_ok_sp  = 1'b0;
          saw_err    = 1'b0;
          saw_err_sp = 1'b0;
        end else begin
          if (col >= 5 || event_text[col] != c) event_miss = 1'b1;
          if (col < 4 && c >= rlc_pkg::CH_ZERO && c <= rlc_pkg::CH_NINE)
            seq_acc = seq_acc * 14'd10 + {6'd0, c - rlc_pkg::CH_ZERO};
          else
            seq_good = 1'b0;
          bump();
        end
      end
      IN_GAP: begin
        if (!(c == rlc_pkg::CH_SP || c == rlc_pkg::CH_TAB || c == rlc_pkg::CH_VT ||
              c == rlc_pkg::CH_FF || c == rlc_pkg::CH_CR)) begin
          phase = IN_BODY;
          col   = 0;
          body_step(c);
        end
      end
      IN_BODY: begin
        body_step(c);
      end
      default: begin
      end
    endcase
  endfunction

  // Work out the verdict for the line just ended
  function line_verdict_t verdict();
    line_verdict_t v;
    int            found;
    v           = '0;
    v.line_kind = rlc_pkg::KIND_UNSOL;
    found       = -1;
    if (phase == IN_TOKEN) begin
      v.line_kind = (!event_miss && col == 5) ? rlc_pkg::KIND_EVENT : rlc_pkg::KIND_UNSOL;
    end else if (phase == IN_EVENT) begin
      v.line_kind = rlc_pkg::KIND_EVENT;
    end else if (!seq_good) begin
      if ((saw_ok && col >= 2) || (saw_err && col >= 3)) begin
        v.line_kind        = rlc_pkg::KIND_MALF;
        v.malformed_reason = rlc_pkg::MR_BAD_SEQ;
      end
    end else begin
      v.has_sequence    = 1'b1;
      v.sequence_number = seq_acc;
      if (saw_ok && col == 2) begin
        v.line_kind = rlc_pkg::KIND_RESP;
      end else if (saw_ok_sp) begin
        v.line_kind   = rlc_pkg::KIND_RESP;
        v.has_payload = saw_payload;
      end else if (saw_err_sp) begin
        for (int w = 0; w < 8; w++) begin
          if (word_alive[w] && col >= 4 && err_word[w].len() == col - 4) found = w;
        end
        if (found >= 0) begin
          v.line_kind     = rlc_pkg::KIND_RESP;
          v.response_kind = 1'b1;
          v.error_code    = 3'(found);
        end else begin
          v.line_kind        = rlc_pkg::KIND_MALF;
          v.malformed_reason = rlc_pkg::MR_BAD_ERR;
        end
      end else begin
        v.line_kind        = rlc_pkg::KIND_MALF;
        v.malformed_reason = rlc_pkg::MR_NO_VERB;
      end
    end
    return v;
  endfunction

  // Take one accepted input beat; a newline queues a verdict
  function void note_byte(logic [7:0] c);
    if (c == rlc_pkg::CH_LF) begin
      cr_held = 1'b0;
      pending.insert(pending.size(), verdict());
      start_line();
      return;
    end
    // a held carriage return not followed by a newline is an ordinary character
    if (cr_held) begin
      cr_held = 1'b0;
      scan_char(rlc_pkg::CH_CR);
    end
    if (c == rlc_pkg::CH_CR) begin
      cr_held = 1'b1;
      return;
    end
    scan_char(c);
  endfunction

  function string describe(line_verdict_t v);
    return $sformatf("kind %0d seq %0d/%0d resp %0d err %0d payload %0d reason %0d",
                     v.line_kind, v.has_sequence, v.sequence_number, v.response_kind,
                     v.error_code, v.has_payload, v.malformed_reason);
  endfunction

  // Check one accepted output beat against the oldest verdict due
  function void check_class(line_verdict_t got);
    line_verdict_t want;
    string         bad;
    lines_checked++;
    if (pending.size() == 0) begin
      failures++;
      if (failures <= 10)
        $display("classification with nothing due: %s", describe(got));
      return;
    end
    want = pending.pop_front();
    kind_seen[want.line_kind]++;
    bad = "";
    if (got.line_kind !== want.line_kind) bad = {bad, " line_kind"};
    if (got.has_sequence !== want.has_sequence) bad = {bad, " has_sequence"};
    if (got.sequence_number !== want.sequence_number) bad = {bad, " sequence_number"};
    if (got.response_kind !== want.response_kind) bad = {bad, " response_kind"};
    if (got.error_code !== want.error_code) bad = {bad, " error_code"};
    if (got.has_payload !== want.has_payload) bad = {bad, " has_payload"};
    if (got.malformed_reason !== want.malformed_reason) bad = {bad, " malformed_reason"};
    if (bad != "") begin
      failures++;
      if (failures <= 10) begin
        $display("line %0d differs in%s", lines_checked, bad);
        $display("  expected %s", describe(want));
        $display("  actual   %s", describe(got));
      end
    end
  endfunction
endclass

module response_line_classifier_top_tb;

  localparam int unsigned RANDOM_BYTES = 830;
  localparam int unsigned STUCK_LIMIT  = 3000;
  localparam int unsigned HOLD_OFF     = 250;

  logic        clk;
  logic        rst         = 1'b1;
  logic        byte_valid  = 1'b0;
  logic        byte_stall;
  logic [7:0]  line_byte   = 8'h00;
  logic        class_valid;
  logic        class_stall = 1'b0;
  logic [1:0]  line_kind;
  logic        has_sequence;
  logic [13:0] sequence_number;
  logic        response_kind;
  logic [2:0]  error_code;
  logic        has_payload;
  logic [1:0]  malformed_reason;

  line_class_book book = new();
  logic [7:0]     byte_stream [$];
  bit             calm = 1'b0;

  response_line_classifier_top DUT (
    .clk              (clk),
    .rst              (rst),
    .byte_valid       (byte_valid),
    .byte_stall       (byte_stall),
    .line_byte        (line_byte),
    .class_valid      (class_valid),
    .class_stall      (class_stall),
    .line_kind        (line_kind),
    .has_sequence     (has_sequence),
    .sequence_number  (sequence_number),
    .response_kind    (response_kind),
    .error_code       (error_code),
    .has_payload      (has_payload),
    .malformed_reason (malformed_reason)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // Stream building
  function automatic void put_byte(logic [7:0] b);
    byte_stream.insert(byte_stream.size(), b);
  endfunction

  function automatic void put_text(string s);
    for (int i = 0; i < s.len(); i++) put_byte(s[i]);
  endfunction

  function automatic void put_line(string s);
    put_text(s);
    put_byte(rlc_pkg::CH_LF);
  endfunction

  // Printable text; with no_space set the space is left out
  function automatic void put_printable(int unsigned n, bit no_space);
    for (int unsigned i = 0; i < n; i++)
      put_byte(8'($urandom_range(no_space ? 33 : 32, 126)));
  endfunction

  // Space or tab, then sometimes further whitespace of any kind
  function automatic void put_gap();
    int unsigned extra;
    put_byte($urandom_range(0, 1) ? rlc_pkg::CH_SP : rlc_pkg::CH_TAB);
    extra = $urandom_range(0, 2);
    for (int unsigned i = 0; i < extra; i++) begin
      case ($urandom_range(0, 4))
        0: put_byte(rlc_pkg::CH_SP);
        1: put_byte(rlc_pkg::CH_TAB);
        2: put_byte(rlc_pkg::CH_VT);
        3: put_byte(rlc_pkg::CH_FF);
        default: put_byte(rlc_pkg::CH_CR);
      endcase
    end
  endfunction

  // An error word, mostly exact, sometimes cut short, stretched or wrong
  function automatic string pick_err_word();
    string w;
    w = book.err_word[$urandom_range(0, 7)];
    case ($urandom_range(0, 9))
      7: return w.substr(0, w.len() - 2);
      8: return {w, "x"};
      9: return "oops";
      default: return w;
    endcase
  endfunction

  // One random reply line, mostly well formed, sometimes noise or damaged
  function automatic void put_random_line();
    int unsigned pick;
    int unsigned start;
    int unsigned n;
    int unsigned spot;
    logic [7:0]  b;
    string       seq;
    start = byte_stream.size();
    pick  = $urandom_range(0, 99);
    seq   = $sformatf("%04d", $urandom_range(0, 9999));
    if (pick < 30) begin
      put_text(seq);
      put_gap();
      put_text("ok");
      if ($urandom_range(0, 2) != 0) begin
        put_byte(rlc_pkg::CH_SP);
        put_printable($urandom_range(0, 20), 1'b0);
      end
    end else if (pick < 55) begin
      put_text(seq);
      put_gap();
      put_text("err ");
      put_text(pick_err_word());
    end else if (pick < 65) begin
      put_text("event");
      if ($urandom_range(0, 1)) begin
        put_byte(rlc_pkg::CH_SP);
        put_printable($urandom_range(0, 12), 1'b0);
      end
    end else if (pick < 75) begin
      put_printable($urandom_range(1, 12), 1'b1);
    end else if (pick < 85) begin
      // broken sequence token ahead of a plausible verb
      n = $urandom_range(1, 6);
      for (int unsigned i = 0; i < n; i++)
        put_byte($urandom_range(0, 3) ? 8'($urandom_range(48, 57)) : 8'($urandom_range(97, 122)));
      put_gap();
      case ($urandom_range(0, 2))
        0: put_text("ok");
        1: put_text({"err ", pick_err_word()});
        default: put_printable($urandom_range(1, 8), 1'b0);
      endcase
    end else begin
      n = $urandom_range(0, 20);
      for (int unsigned i = 0; i < n; i++) begin
        b = 8'($urandom_range(0, 255));
        put_byte(b == rlc_pkg::CH_LF ? rlc_pkg::CH_VT : b);
      end
    end
    // damage one byte now and then
    if ($urandom_range(0, 9) == 0 && byte_stream.size() > start) begin
      spot = $urandom_range(start, byte_stream.size() - 1);
      b    = 8'($urandom_range(0, 255));
      byte_stream[spot] = (b == rlc_pkg::CH_LF) ? rlc_pkg::CH_FF : b;
    end
    if ($urandom_range(0, 3) == 0) put_byte(rlc_pkg::CH_CR);
    put_byte(rlc_pkg::CH_LF);
  endfunction

  // Directed lines first, then random lines up to the byte budget
  function automatic void build_stimulus();
    int unsigned directed_end;
    put_line("event");
    put_line("event alarm");
    put_line("event\tx");
    put_line("hello");
    put_line("");
    put_line("0000 ok");
    put_line("9999 ok done");
    put_line("1234 ok ");
    for (int w = 0; w < 8; w++) begin
      put_text({$sformatf("%04d", 1111 * w + 8), " err ", book.err_word[w]});
      if (w == 3) put_byte(rlc_pkg::CH_CR);
      put_byte(rlc_pkg::CH_LF);
    end
    put_line("0042 err nope");
    put_line("0042 errx");
    put_line("12a4 ok");
    put_line("123 err busy");
    put_line("0007 ok this payload runs well past fifteen columns");
    put_line("0007 err unsupportedly");
    // inner carriage return in the gap, then a dropped one before the newline
    put_text("0042\t ");
    put_byte(rlc_pkg::CH_VT);
    put_byte(rlc_pkg::CH_FF);
    put_byte(rlc_pkg::CH_CR);
    put_text(" ok");
    put_byte(rlc_pkg::CH_CR);
    put_byte(rlc_pkg::CH_LF);
    // two carriage returns: only the last one is dropped
    put_text("0001 ok");
    put_byte(rlc_pkg::CH_CR);
    put_byte(rlc_pkg::CH_CR);
    put_byte(rlc_pkg::CH_LF);
    put_line("0042 ");
    put_byte(8'hFF);
    put_byte(8'h80);
    put_byte(8'h00);
    put_line(" ok");
    put_line("evente");
    put_line("event ");
    directed_end = byte_stream.size();
    while (byte_stream.size() < directed_end + RANDOM_BYTES) put_random_line();
  endfunction

  // Offer each byte in turn; hold the beat while stalled
  task automatic send_bytes();
    int unsigned k;
    int unsigned calm_lo;
    int unsigned calm_hi;
    k       = 0;
    calm_lo = byte_stream.size() * 2 / 5;
    calm_hi = byte_stream.size() * 3 / 5;
    while (k < byte_stream.size()) begin
      calm = (k >= calm_lo && k < calm_hi);
      if (calm || $urandom_range(0, 99) >= 31) begin
        byte_valid <= 1'b1;
        line_byte  <= byte_stream[k];
        do @(posedge clk); while (byte_stall !== 1'b0);
        k++;
      end else begin
        byte_valid <= 1'b0;
        @(posedge clk);
      end
    end
    byte_valid <= 1'b0;
    calm = 1'b0;
  endtask

  // Stall the output at random; hold off once for a long stretch to fill the block
  task automatic pace_receiver();
    int unsigned hold_left;
    bit          held_once;
    hold_left = 0;
    held_once = 1'b0;
    forever begin
      if (!held_once && book.lines_checked >= 40) begin
        held_once = 1'b1;
        hold_left = HOLD_OFF;
      end
      if (hold_left > 0) begin
        class_stall <= 1'b1;
        hold_left--;
      end else begin
        class_stall <= !calm && ($urandom_range(0, 99) < 31);
      end
      @(posedge clk);
    end
  endtask

  // Watch both channels at every edge
  always @(posedge clk) begin
    if (!rst && class_valid === 1'b1 && class_stall === 1'b0)
      book.check_class('{line_kind: line_kind, has_sequence: has_sequence,
                         sequence_number: sequence_number, response_kind: response_kind,
                         error_code: error_code, has_payload: has_payload,
                         malformed_reason: malformed_reason});
    if (!rst && byte_valid && byte_stall === 1'b0)
      book.note_byte(line_byte);
  end

  // End the run if neither channel moves for too long
  initial begin : watchdog
    int unsigned stuck;
    stuck = 0;
    while (stuck < STUCK_LIMIT) begin
      @(posedge clk);
      if ((byte_valid && byte_stall === 1'b0) || (class_valid === 1'b1 && class_stall === 1'b0))
        stuck = 0;
      else
        stuck++;
    end
    $display("no beat moved for %0d cycles", STUCK_LIMIT);
    $display("simulation failed");
    $finish;
  end

  initial begin
    build_stimulus();
    repeat (3) @(posedge clk);
    rst <= 1'b0;
    fork
      pace_receiver();
    join_none
    send_bytes();
    // drain the verdicts still due, then give the pipeline time to show strays
    while (book.pending.size() != 0) @(posedge clk);
    repeat (8) @(posedge clk);
    $display("%0d bytes sent, %0d lines classified, %0d faults", byte_stream.size(),
             book.lines_checked, book.failures);
    $display("lines by kind: event %0d, unsolicited %0d, response %0d, malformed %0d",
             book.kind_seen[rlc_pkg::KIND_EVENT], book.kind_seen[rlc_pkg::KIND_UNSOL],
             book.kind_seen[rlc_pkg::KIND_RESP], book.kind_seen[rlc_pkg::KIND_MALF]);
    if (book.failures == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end

endmodule
